FILE: rtl/mdepq_pkg.sv
package mdepq_pkg;

	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_POP_MIN = 2'd1;
	localparam logic [1:0] KIND_POP_MAX = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Read offsets relative to the head of the circular store.
	localparam logic [1:0] OFF_ZERO = 2'd0;
	localparam logic [1:0] OFF_J1   = 2'd1;
	localparam logic [1:0] OFF_MED  = 2'd2;
	localparam logic [1:0] OFF_LAST = 2'd3;

	localparam logic [2:0] CAP_NONE = 3'd0;
	localparam logic [2:0] CAP_REM  = 3'd1;
	localparam logic [2:0] CAP_MIN  = 3'd2;
	localparam logic [2:0] CAP_MED  = 3'd3;
	localparam logic [2:0] CAP_MAX  = 3'd4;
	localparam logic [2:0] CAP_ZERO = 3'd5;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] priority_req;
		logic [15:0]        tag;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_priority;
		logic [15:0]        removed_tag;
		logic [6:0]         count;
		logic signed [31:0] min_priority;
		logic [15:0]        min_tag;
		logic signed [31:0] median_priority;
		logic [15:0]        median_tag;
		logic signed [31:0] max_priority;
		logic [15:0]        max_tag;
	} out_word_t;

	typedef struct packed {
		logic       load;
		logic [1:0] rd_off;
		logic       wr_en;
		logic       wr_new;
		logic       j_dec;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       head_inc;
		logic [2:0] cap;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       full;
		logic       empty;
		logic       j_zero;
		logic       gt;
	} stat_t;

endpackage

FILE: rtl/mdepq_ctrl.sv
module mdepq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_kind,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mdepq_pkg::stat_t    stat,
	output mdepq_pkg::cmd_t     cmd
);
	import mdepq_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_CHK = 4'd1;
	localparam logic [3:0] S_INS_CMP = 4'd2;
	localparam logic [3:0] S_REM_CAP = 4'd3;
	localparam logic [3:0] S_VIEW0   = 4'd4;
	localparam logic [3:0] S_VIEW1   = 4'd5;
	localparam logic [3:0] S_VIEW2   = 4'd6;
	localparam logic [3:0] S_VIEW3   = 4'd7;
	localparam logic [3:0] S_OUT     = 4'd8;

	logic [3:0] state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_kind)
						KIND_INSERT:  state_d = stat.full ? S_VIEW0 : S_INS_CHK;
						KIND_POP_MIN: begin
							cmd.rd_off = OFF_ZERO;
							state_d = stat.empty ? S_VIEW0 : S_REM_CAP;
						end
						KIND_POP_MAX: begin
							cmd.rd_off = OFF_LAST;
							state_d = stat.empty ? S_VIEW0 : S_REM_CAP;
						end
						default: state_d = S_VIEW0;
					endcase
				end
			end
			S_INS_CHK: begin
				if (stat.j_zero) begin
					cmd.wr_en = 1'b1;
					cmd.wr_new = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = S_VIEW0;
				end else begin
					cmd.rd_off = OFF_J1;
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (stat.gt) begin
					// Shift the larger entry up one slot and keep scanning down.
					cmd.j_dec = 1'b1;
					state_d = S_INS_CHK;
				end else begin
					cmd.wr_new = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = S_VIEW0;
				end
			end
			S_REM_CAP: begin
				cmd.cap = CAP_REM;
				cmd.cnt_dec = 1'b1;
				cmd.head_inc = (stat.kind == KIND_POP_MIN);
				state_d = S_VIEW0;
			end
			S_VIEW0: begin
				if (stat.empty) begin
					cmd.cap = CAP_ZERO;
					state_d = S_OUT;
				end else begin
					cmd.rd_off = OFF_ZERO;
					state_d = S_VIEW1;
				end
			end
			S_VIEW1: begin
				cmd.cap = CAP_MIN;
				cmd.rd_off = OFF_MED;
				state_d = S_VIEW2;
			end
			S_VIEW2: begin
				cmd.cap = CAP_MED;
				cmd.rd_off = OFF_LAST;
				state_d = S_VIEW3;
			end
			S_VIEW3: begin
				cmd.cap = CAP_MAX;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/mdepq_dpath.sv
module mdepq_dpath #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdepq_pkg::in_word_t  in_word,
	input  mdepq_pkg::cmd_t      cmd,
	output mdepq_pkg::stat_t     stat,
	output mdepq_pkg::out_word_t out_word
);
	import mdepq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [31:0]  prio;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	entry_t mem [CAPACITY];
	entry_t rdata_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [1:0]    kind_q;
	logic signed [31:0]  key_q;
	logic [TAG_BITS-1:0] ntag_q;
	logic [1:0]    status_q;
	entry_t        rem_q, min_q, med_q, max_q;

	logic [CW-1:0] off;
	logic [AW-1:0] raddr, waddr;
	entry_t        wdata;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] ofs);
		logic [AW+CW:0] sum;
		sum = (AW + CW + 1)'(base) + (AW + CW + 1)'(ofs);
		if (sum >= (AW + CW + 1)'(CAPACITY)) begin
			sum = sum - (AW + CW + 1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	always_comb begin
		case (cmd.rd_off)
			OFF_ZERO: off = '0;
			OFF_J1:   off = j_q - CW'(1);
			OFF_MED:  off = (count_q - CW'(1)) >> 1;
			OFF_LAST: off = count_q - CW'(1);
			default:  off = '0;
		endcase
	end

	assign raddr = wrap(head_q, off);
	assign waddr = wrap(head_q, j_q);
	assign wdata = cmd.wr_new ? entry_t'{key_q, ntag_q} : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.head_inc) begin
				head_q <= wrap(head_q, CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_word.kind;
			key_q  <= in_word.priority_req;
			ntag_q <= TAG_BITS'(in_word.tag);
			j_q    <= count_q;
			rem_q  <= '0;
			if (in_word.kind == KIND_INSERT && count_q == CW'(CAPACITY)) begin
				status_q <= ST_FULL;
			end else if ((in_word.kind == KIND_POP_MIN || in_word.kind == KIND_POP_MAX)
					&& count_q == '0) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end else if (cmd.j_dec) begin
			j_q <= j_q - CW'(1);
		end
		case (cmd.cap)
			CAP_REM: rem_q <= rdata_q;
			CAP_MIN: min_q <= rdata_q;
			CAP_MED: med_q <= rdata_q;
			CAP_MAX: max_q <= rdata_q;
			CAP_ZERO: begin
				min_q <= '0;
				med_q <= '0;
				max_q <= '0;
			end
			default: ;
		endcase
	end

	assign stat.kind   = kind_q;
	assign stat.full   = (count_q == CW'(CAPACITY));
	assign stat.empty  = (count_q == '0);
	assign stat.j_zero = (j_q == '0);
	assign stat.gt     = (rdata_q.prio > key_q);

	always_comb begin
		out_word.status           = status_q;
		out_word.removed_priority = rem_q.prio;
		out_word.removed_tag      = 16'(rem_q.tag);
		out_word.count            = 7'(count_q);
		out_word.min_priority     = min_q.prio;
		out_word.min_tag          = 16'(min_q.tag);
		out_word.median_priority  = med_q.prio;
		out_word.median_tag       = 16'(med_q.tag);
		out_word.max_priority     = max_q.prio;
		out_word.max_tag          = 16'(max_q.tag);
	end

endmodule

FILE: rtl/median_double_ended_priority_queue_top.sv
// An insert shifts each held entry with a greater priority up one slot before writing the new
// entry (one memory read and one write per shifted entry, single-port read on the sorted
// store); a remove captures its entry first, and error or unused kinds go straight to the view.
// Throughput: one word in flight; the next word is taken after the result is taken.
// Reset: arst_n clears the count, head pointer and controller; the store is not cleared.
module median_double_ended_priority_queue_top #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mdepq_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mdepq_pkg::out_word_t out_word
);
	import mdepq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mdepq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_word.kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mdepq_dpath #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.stat     (stat),
		.out_word (out_word)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready stayed high after accept");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && stat.full)) else $error("insert into a full store");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_dec && stat.empty)) else $error("removal from an empty store");

endmodule

FILE: dv/median_double_ended_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module median_double_ended_priority_queue_top_tb;
	import mdepq_pkg::*;

	localparam int CAP = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic signed [31:0] prio;
		logic [15:0]        tag;
	} entry_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	entry_t    held[$];
	out_word_t pending_views[$];
	int        mismatches;
	int        idle_cycles;
	int        hold_off;
	bit        stall_mode;

	median_double_ended_priority_queue_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(10, 40);
		end
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	// Applies one word to the sorted copy and returns the view the block must report.
	function automatic out_word_t apply_word(in_word_t w);
		out_word_t r;
		entry_t    e;
		int        pos;
		int        n;
		r = '0;
		r.status = ST_OK;
		if (w.kind == KIND_INSERT) begin
			if (held.size() >= CAP) begin
				r.status = ST_FULL;
			end else begin
				e.prio = w.priority_req;
				e.tag = w.tag;
				pos = held.size();
				for (int i = 0; i < held.size(); i++) begin
					if (held[i].prio > e.prio) begin
						pos = i;
						break;
					end
				end
				held.insert(pos, e);
			end
		end else if (w.kind == KIND_POP_MIN || w.kind == KIND_POP_MAX) begin
			if (held.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				e = (w.kind == KIND_POP_MIN) ? held.pop_front() : held.pop_back();
				r.removed_priority = e.prio;
				r.removed_tag = e.tag;
			end
		end
		n = held.size();
		r.count = n[6:0];
		if (n > 0) begin
			r.min_priority = held[0].prio;
			r.min_tag = held[0].tag;
			r.median_priority = held[(n + 1) / 2 - 1].prio;
			r.median_tag = held[(n + 1) / 2 - 1].tag;
			r.max_priority = held[n - 1].prio;
			r.max_tag = held[n - 1].tag;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s got %0h expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	// Valid drops only when a gap follows, so a back-to-back word keeps it high.
	task automatic send_word(logic [1:0] kind, logic signed [31:0] prio, logic [15:0] tag);
		in_word_t w;
		int       gap;
		gap = short_or_long_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
		end
		repeat (gap) @(posedge clk);
		w.kind = kind;
		w.priority_req = prio;
		w.tag = tag;
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		pending_views.push_back(apply_word(w));
	endtask

	// Receiver side: random stalls, or one long counted hold-off when asked.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (stall_mode) begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_views.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				want = pending_views.pop_front();
				if (out_word.status !== want.status)
					report_mismatch("status", out_word.status, want.status);
				if (out_word.removed_priority !== want.removed_priority)
					report_mismatch("removed_priority", out_word.removed_priority,
						want.removed_priority);
				if (out_word.removed_tag !== want.removed_tag)
					report_mismatch("removed_tag", out_word.removed_tag, want.removed_tag);
				if (out_word.count !== want.count)
					report_mismatch("count", out_word.count, want.count);
				if (out_word.min_priority !== want.min_priority)
					report_mismatch("min_priority", out_word.min_priority, want.min_priority);
				if (out_word.min_tag !== want.min_tag)
					report_mismatch("min_tag", out_word.min_tag, want.min_tag);
				if (out_word.median_priority !== want.median_priority)
					report_mismatch("median_priority", out_word.median_priority,
						want.median_priority);
				if (out_word.median_tag !== want.median_tag)
					report_mismatch("median_tag", out_word.median_tag, want.median_tag);
				if (out_word.max_priority !== want.max_priority)
					report_mismatch("max_priority", out_word.max_priority, want.max_priority);
				if (out_word.max_tag !== want.max_tag)
					report_mismatch("max_tag", out_word.max_tag, want.max_tag);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] random_priority();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7) - 4;
			1: return (($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_extremes_and_errors();
		send_word(KIND_POP_MIN, 0, 0);
		send_word(KIND_POP_MAX, 0, 0);
		send_word(KIND_UNUSED, 32'sh12345678, 16'hffff);
		send_word(KIND_INSERT, 32'sh7fffffff, 16'hffff);
		send_word(KIND_INSERT, 32'sh80000000, 16'h0000);
		send_word(KIND_INSERT, 32'sh0, 16'h5555);
		send_word(KIND_INSERT, 32'sh0, 16'haaaa);
		send_word(KIND_INSERT, 32'sh0, 16'h1234);
		send_word(KIND_UNUSED, 32'sh0, 16'h0);
		send_word(KIND_POP_MAX, 0, 0);
		send_word(KIND_POP_MIN, 0, 0);
		send_word(KIND_POP_MIN, 0, 0);
		send_word(KIND_POP_MIN, 0, 0);
		send_word(KIND_POP_MAX, 0, 0);
		send_word(KIND_POP_MAX, 0, 0);
	endtask

	// Fills to capacity and beyond; the receiver holds off so the input stalls.
	task automatic test_fill_under_backpressure();
		hold_off = 300;
		for (int i = 0; i < CAP + 2; i++) begin
			send_word(KIND_INSERT, ($urandom_range(0, 1) == 1) ? random_priority() : 5,
				16'($urandom()));
		end
		for (int i = 0; i < CAP + 2; i++) begin
			send_word(($urandom_range(0, 1) == 1) ? KIND_POP_MIN : KIND_POP_MAX, 0, 0);
		end
	endtask

	task automatic test_random_mix(int items);
		int k;
		logic [1:0] kind;
		stall_mode = 1'b1;
		for (int i = 0; i < items; i++) begin
			k = $urandom_range(0, 99);
			// Lean toward inserts while small, toward removals while near full.
			if (k < ((held.size() < 40) ? 55 : 35)) kind = KIND_INSERT;
			else if (k < 76) kind = KIND_POP_MIN;
			else if (k < 97) kind = KIND_POP_MAX;
			else kind = KIND_UNUSED;
			send_word(kind, random_priority(), 16'($urandom()));
		end
		stall_mode = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 0;
		stall_mode = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes_and_errors();
		test_fill_under_backpressure();
		test_random_mix(800);
		in_valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_views.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
